// ===== sv/assert_macros.svh =====
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is held
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// next-cycle implication, disabled while reset is held
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ===== sv/nsr_pkg.sv =====
// package for the newton square root block: constants, codes and shared types
`timescale 1ns / 1ps
`default_nettype none
package nsr_pkg;

    // default format of the fixed-point value
    localparam int FRAC_BITS_DEF   = 16;
    localparam int VALUE_WIDTH_DEF = 32;

    // configuration register widths and reset values
    localparam int STEP_W     = 6;
    localparam int TOL_W      = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [STEP_W-1:0] MAX_STEPS_RST = 6'd40;
    localparam logic [TOL_W-1:0]  TOLERANCE_RST = 16'd66;

    // multiplier operand slice handled per cycle
    localparam int MUL_CHUNK = 16;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_STEPS = 1'b0,
        CFG_TOLERANCE = 1'b1
    } t_cfg_idx;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_DIV,
        S_UPD,
        S_MUL,
        S_CMP
    } t_state;

    // sequencer to datapath controls
    typedef struct packed {
        logic load;
        logic div_init;
        logic div_step;
        logic upd;
        logic mul_step;
    } t_dp_ctrl;

    // datapath to sequencer status
    typedef struct packed {
        logic g_zero;
        logic div_last;
        logic mul_last;
        logic close;
    } t_dp_stat;

endpackage
`default_nettype wire

// ===== sv/nsr_unit.sv =====
// shared arithmetic unit: restoring divider, chunked squarer and tolerance compare
`timescale 1ns / 1ps
`default_nettype none
module nsr_unit #(
    parameter int VALUE_WIDTH = nsr_pkg::VALUE_WIDTH_DEF,
    parameter int FRAC_BITS   = nsr_pkg::FRAC_BITS_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire nsr_pkg::t_dp_ctrl         i_ctrl,
    input  wire logic [VALUE_WIDTH-1:0]    i_value,
    input  wire logic [nsr_pkg::TOL_W-1:0] i_tolerance,
    output nsr_pkg::t_dp_stat              o_stat,
    output logic [VALUE_WIDTH-1:0]         o_guess
);
    import nsr_pkg::*;

    localparam int DIV_N = VALUE_WIDTH + FRAC_BITS;
    localparam int CNT_W = $clog2(DIV_N);
    localparam int NCH   = (VALUE_WIDTH + MUL_CHUNK - 1) / MUL_CHUNK;
    localparam int MPW   = NCH * MUL_CHUNK;
    localparam int AW    = MPW + VALUE_WIDTH;
    localparam int PPW   = VALUE_WIDTH + MUL_CHUNK;

    logic [VALUE_WIDTH-1:0] r_v;
    logic [VALUE_WIDTH-1:0] r_g;
    logic [DIV_N-1:0]       r_dq;
    logic [VALUE_WIDTH-1:0] r_rem;
    logic [MPW-1:0]         r_mplr;
    logic [AW-1:0]          r_acc;
    logic [CNT_W-1:0]       r_cnt;

    logic [VALUE_WIDTH:0]   rem_sh;
    logic [VALUE_WIDTH+1:0] diff;
    logic                   q_bit;
    logic [VALUE_WIDTH-1:0] q_sat;
    logic [VALUE_WIDTH:0]   g_sum;
    logic [VALUE_WIDTH-1:0] g_new;
    logic [PPW-1:0]         pp;
    logic [PPW-1:0]         psum;
    logic [AW+MUL_CHUNK-1:0] acc_wide;
    logic [VALUE_WIDTH:0]   lim;

    // one restoring division step: shift in the next numerator bit, trial subtract
    assign rem_sh = {r_rem, r_dq[DIV_N-1]};
    assign diff   = {1'b0, rem_sh} - {2'b00, r_g};
    assign q_bit  = ~diff[VALUE_WIDTH+1];

    // saturate the quotient to the value width, then average with the guess
    assign q_sat = (|r_dq[DIV_N-1:VALUE_WIDTH]) ? {VALUE_WIDTH{1'b1}}
                                                 : r_dq[VALUE_WIDTH-1:0];
    assign g_sum = {1'b0, r_g} + {1'b0, q_sat};
    assign g_new = g_sum[VALUE_WIDTH:1];

    // one squaring slice: partial product added at the top, accumulator shifts right
    assign pp       = PPW'(r_g) * PPW'(r_mplr[MUL_CHUNK-1:0]);
    assign psum     = PPW'(r_acc[AW-1:MPW]) + pp;
    assign acc_wide = {psum, r_acc[MPW-1:0]};

    // squared guess, scaled down, against value plus tolerance
    assign lim = {1'b0, r_v} + (VALUE_WIDTH+1)'(i_tolerance);

    // status towards the sequencer
    always_comb begin
        o_stat.g_zero   = (r_g == '0);
        o_stat.div_last = (r_cnt == CNT_W'(DIV_N - 1));
        o_stat.mul_last = (r_cnt == CNT_W'(NCH - 1));
        o_stat.close    = ((r_acc >> FRAC_BITS) <= AW'(lim));
    end

    assign o_guess = r_g;

    // step counter shared by divider and squarer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_ctrl.div_init || i_ctrl.upd) begin
            r_cnt <= '0;
        end else if (i_ctrl.div_step || i_ctrl.mul_step) begin
            r_cnt <= r_cnt + 1'b1;
        end
    end

    // operand, divider and accumulator registers
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_v <= i_value;
            r_g <= i_value;
        end
        if (i_ctrl.div_init) begin
            r_dq  <= {r_v, {FRAC_BITS{1'b0}}};
            r_rem <= '0;
        end else if (i_ctrl.div_step) begin
            r_dq  <= {r_dq[DIV_N-2:0], q_bit};
            r_rem <= q_bit ? diff[VALUE_WIDTH-1:0] : rem_sh[VALUE_WIDTH-1:0];
        end
        if (i_ctrl.upd) begin
            r_g    <= g_new;
            r_mplr <= MPW'(g_new);
            r_acc  <= '0;
        end else if (i_ctrl.mul_step) begin
            r_mplr <= r_mplr >> MUL_CHUNK;
            r_acc  <= acc_wide[AW+MUL_CHUNK-1:MUL_CHUNK];
        end
    end

endmodule
`default_nettype wire

// ===== sv/newton_square_root_top.sv =====
// top level of the newton square root block: sequencer, configuration and result registers
//
// usage
//   command channel: i_value is taken at a rising edge with start high and busy low;
//   busy then stays high until the result has been issued.
//   result: o_root and o_found are shown for exactly one cycle with o_done high,
//   one result per command; the receiver cannot stall, so it must take it then.
//   configuration: i_cfg_index / i_cfg_data written when i_cfg_valid and o_cfg_ready
//   are high (o_cfg_ready is always high); index 0 is max_steps, index 1 tolerance.
//   write configuration only while busy is low.
// operation
//   each newton step runs a check, a bit-serial restoring division, an update, a
//   chunked squaring and a compare (Q16.16 by default). o_done rises after the
//   compare of the step that converges, or after the check that stops the command;
//   busy falls as o_done rises, so the next command can be taken in that cycle.
//   a zero input or zero guess, or reaching max_steps, gives root 0 with found 0.
// reset
//   synchronous active-low reset returns to idle, drops o_done and restores
//   max_steps to 40 and tolerance to 66.
`timescale 1ns / 1ps
`default_nettype none
module newton_square_root_top #(
    parameter int VALUE_WIDTH = nsr_pkg::VALUE_WIDTH_DEF,
    parameter int FRAC_BITS   = nsr_pkg::FRAC_BITS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic [VALUE_WIDTH-1:0]         i_value,
    output logic                                o_done,
    output logic [VALUE_WIDTH-1:0]              o_root,
    output logic                                o_found,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [nsr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [nsr_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import nsr_pkg::*;

    t_state                 r_state;
    t_state                 n_state;
    logic [STEP_W-1:0]      r_step;
    logic [STEP_W-1:0]      r_max_steps;
    logic [TOL_W-1:0]       r_tolerance;
    logic                   r_done;
    logic                   r_found;
    logic [VALUE_WIDTH-1:0] r_root;

    t_dp_ctrl               ctrl;
    t_dp_stat               stat;
    logic [VALUE_WIDTH-1:0] guess;
    logic                   accept;
    logic                   stop_fail;
    logic                   emit_ok;
    logic                   emit_fail;
    logic                   step_clr;
    logic                   step_inc;

    assign accept    = start && (r_state == S_IDLE);
    assign stop_fail = (r_step == r_max_steps) || stat.g_zero;

    // shared arithmetic unit
    nsr_unit #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_unit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (ctrl),
        .i_value     (i_value),
        .i_tolerance (r_tolerance),
        .o_stat      (stat),
        .o_guess     (guess)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (accept) n_state = S_CHECK;
            S_CHECK: n_state = stop_fail ? S_IDLE : S_DIV;
            S_DIV:   if (stat.div_last) n_state = S_UPD;
            S_UPD:   n_state = S_MUL;
            S_MUL:   if (stat.mul_last) n_state = S_CMP;
            S_CMP:   n_state = stat.close ? S_IDLE : S_CHECK;
            default: n_state = S_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        ctrl      = '0;
        emit_ok   = 1'b0;
        emit_fail = 1'b0;
        step_clr  = 1'b0;
        step_inc  = 1'b0;
        case (r_state)
            S_IDLE: begin
                ctrl.load = accept;
                step_clr  = accept;
            end
            S_CHECK: begin
                emit_fail     = stop_fail;
                ctrl.div_init = !stop_fail;
            end
            S_DIV: begin
                ctrl.div_step = 1'b1;
            end
            S_UPD: begin
                ctrl.upd = 1'b1;
                step_inc = 1'b1;
            end
            S_MUL: begin
                ctrl.mul_step = 1'b1;
            end
            S_CMP: begin
                emit_ok = stat.close;
            end
            default: begin
                ctrl = '0;
            end
        endcase
    end

    // state and step count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            if (step_clr) begin
                r_step <= '0;
            end else if (step_inc) begin
                r_step <= r_step + 1'b1;
            end
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_steps <= MAX_STEPS_RST;
            r_tolerance <= TOLERANCE_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_MAX_STEPS: r_max_steps <= i_cfg_data[STEP_W-1:0];
                CFG_TOLERANCE: r_tolerance <= i_cfg_data[TOL_W-1:0];
                default:       r_tolerance <= r_tolerance;
            endcase
        end
    end

    // result strobe and payload
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= emit_ok || emit_fail;
        end
        if (emit_ok || emit_fail) begin
            r_found <= emit_ok;
            r_root  <= emit_ok ? guess : '0;
        end
    end

    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_done      = r_done;
    assign o_found     = r_found;
    assign o_root      = r_root;

endmodule
`default_nettype wire

// ===== sv/nsr_checker.sv =====
// port-level checker for the newton square root block, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module nsr_checker #(
    parameter int VALUE_WIDTH = nsr_pkg::VALUE_WIDTH_DEF
) (
    input wire logic                   i_clk,
    input wire logic                   i_rst_n,
    input wire logic                   start,
    input wire logic                   busy,
    input wire logic                   o_done,
    input wire logic                   o_found,
    input wire logic [VALUE_WIDTH-1:0] o_root
);
    // a failed result carries a zero root
    `ASSERT_IMPL(a_fail_zero_root, i_clk, i_rst_n, o_done && !o_found, o_root == '0)
    // an accepted command makes the block busy
    `ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy)
    // the strobe lasts a single cycle
    `ASSERT_NEXT(a_done_pulse, i_clk, i_rst_n, o_done, !o_done)
    // a result ends a busy period
    `ASSERT_IMPL(a_done_after_busy, i_clk, i_rst_n, o_done, !busy && $past(busy))
endmodule

bind newton_square_root_top nsr_checker #(
    .VALUE_WIDTH (VALUE_WIDTH)
) u_nsr_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_done  (o_done),
    .o_found (o_found),
    .o_root  (o_root)
);
`default_nettype wire

// ===== verif/tb.sv =====
// testbench for the newton square root block: fixed-point root prediction and result checking
`timescale 1ns / 1ps
module tb;

    localparam int VW = nsr_pkg::VALUE_WIDTH_DEF;
    localparam int FB = nsr_pkg::FRAC_BITS_DEF;
    // longest item: 63 newton steps plus entry and exit
    localparam int ITEM_CYCLES_MAX = 2 + 53 * 63 + 1;
    localparam int CYCLE_LIMIT = 5_000_000;

    // one expected root transaction
    typedef struct {
        logic [VW-1:0] value;
        logic [VW-1:0] root;
        logic          found;
    } t_root_result;

    logic                              i_clk = 1'b0;
    logic                              i_rst_n = 1'b0;
    logic                              start = 1'b0;
    logic                              busy;
    logic [VW-1:0]                     i_value = '0;
    logic                              o_done;
    logic [VW-1:0]                     o_root;
    logic                              o_found;
    logic                              i_cfg_valid = 1'b0;
    logic                              o_cfg_ready;
    logic [nsr_pkg::CFG_IDX_W-1:0]     i_cfg_index = nsr_pkg::CFG_MAX_STEPS;
    logic [nsr_pkg::CFG_DATA_W-1:0]    i_cfg_data = '0;

    // local copy of the step limit and tolerance registers
    logic [nsr_pkg::STEP_W-1:0]        steps_limit = nsr_pkg::MAX_STEPS_RST;
    logic [nsr_pkg::TOL_W-1:0]         tol_limit = nsr_pkg::TOLERANCE_RST;

    t_root_result                      expected_roots[$];
    int unsigned                       mismatch_count = 0;
    int unsigned                       cycle_count = 0;
    bit                                start_high = 1'b0;

    newton_square_root_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_value     (i_value),
        .o_done      (o_done),
        .o_root      (o_root),
        .o_found     (o_found),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // clock
    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // newton iteration from the value itself, truncating division and saturated quotient
    function automatic t_root_result predict_root(input logic [VW-1:0] value);
        t_root_result res;
        logic [63:0]  guess;
        logic [63:0]  quot;
        logic [63:0]  square;
        int unsigned  n;
        bit           failed;
        res.value = value;
        res.root  = '0;
        res.found = 1'b0;
        guess     = 64'(value);
        failed    = 1'b0;
        n         = 0;
        while (n < steps_limit && !res.found && !failed) begin
            if (guess == 0) begin
                failed = 1'b1;
            end else begin
                quot = (64'(value) << FB) / guess;
                if (quot > 64'(VW'('1)))
                    quot = 64'(VW'('1));
                guess  = (guess + quot) >> 1;
                square = (guess * guess) >> FB;
                if (square <= 64'(value) + 64'(tol_limit)) begin
                    res.root  = guess[VW-1:0];
                    res.found = 1'b1;
                end
            end
            n++;
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        mismatch_count++;
    endtask

    // compare each result with the oldest prediction
    always @(posedge i_clk) begin : check_results
        t_root_result want;
        if (i_rst_n && o_done) begin
            if (expected_roots.size() == 0) begin
                report_mismatch($sformatf("unexpected result root=%h found=%b",
                                          o_root, o_found));
            end else begin
                want = expected_roots.pop_front();
                if (o_root !== want.root)
                    report_mismatch($sformatf("value %h: root %h, expected %h",
                                              want.value, o_root, want.root));
                if (o_found !== want.found)
                    report_mismatch($sformatf("value %h: found %b, expected %b",
                                              want.value, o_found, want.found));
            end
        end
    end

    task automatic hold_start_low();
        if (start_high) begin
            start      <= 1'b0;
            start_high = 1'b0;
        end
    endtask

    // send one value, optionally idling first; start is left high after the transaction
    task automatic issue_value(input logic [VW-1:0] value, input int unsigned idle_pct);
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            hold_start_low();
            repeat (($urandom_range(0, 1) != 0) ? $urandom_range(1, 8)
                                                : $urandom_range(1, 1200))
                @(posedge i_clk);
        end
        start      <= 1'b1;
        start_high = 1'b1;
        i_value    <= value;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        expected_roots.push_back(predict_root(value));
    endtask

    // hold off until every predicted root has come back and the block is idle
    task automatic wait_for_all_roots();
        hold_start_low();
        @(posedge i_clk);
        while (expected_roots.size() != 0 || busy)
            @(posedge i_clk);
    endtask

    // write both registers in one burst while the block is idle
    task automatic write_settings(input logic [15:0] steps_word, input logic [15:0] tol_word);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= nsr_pkg::CFG_MAX_STEPS;
        i_cfg_data  <= steps_word;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        steps_limit = steps_word[nsr_pkg::STEP_W-1:0];
        i_cfg_index <= nsr_pkg::CFG_TOLERANCE;
        i_cfg_data  <= tol_word;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        tol_limit = tol_word;
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [VW-1:0] random_value();
        logic [63:0] r;
        case ($urandom_range(0, 5))
            0: return VW'($urandom);
            1: return VW'($urandom_range(0, 255));
            2: return VW'(64'd1 << $urandom_range(0, VW - 1));
            3: begin
                // near-perfect squares
                r = 64'($urandom_range(0, 24'hFF_FFFF));
                return VW'((r * r) >> FB);
            end
            4: return VW'('1) - VW'($urandom_range(0, 255));
            default: return VW'($urandom_range(0, 65535)) << FB;
        endcase
    endfunction

    task automatic pick_random_settings();
        logic [15:0] steps_word;
        logic [15:0] tol_word;
        steps_word = ($urandom_range(0, 1) != 0) ? 16'($urandom_range(0, 65535)) : 16'h0000;
        if ($urandom_range(0, 3) != 0)
            steps_word[nsr_pkg::STEP_W-1:0] = nsr_pkg::STEP_W'($urandom_range(6, 40));
        else
            steps_word[nsr_pkg::STEP_W-1:0] = nsr_pkg::STEP_W'($urandom_range(0, 63));
        case ($urandom_range(0, 3))
            0: tol_word = 16'($urandom_range(0, 65535));
            1: tol_word = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
            default: tol_word = 16'($urandom_range(0, 300));
        endcase
        wait_for_all_roots();
        write_settings(steps_word, tol_word);
    endtask

    // reset values of the registers, edge values, zero input
    task automatic test_reset_defaults();
        logic [VW-1:0] values[12];
        values = '{32'h0000_0000, 32'h0000_0001, 32'h0000_0002, 32'h0000_FFFF,
                   32'h0001_0000, 32'h0002_0000, 32'h0004_0000, 32'h5555_5555,
                   32'h7FFF_FFFF, 32'h8000_0000, 32'hAAAA_AAAA, 32'hFFFF_FFFF};
        foreach (values[i])
            issue_value(values[i], 0);
    endtask

    // step limit 0 at tol 66, 1 and 63 at zero and full tolerance; junk above max_steps
    task automatic test_register_extremes();
        logic [15:0] steps_words[5];
        logic [15:0] tol_words[5];
        steps_words = '{16'hFFC0, 16'h0001, 16'hA5C1, 16'h003F, 16'h003F};
        tol_words   = '{16'd66, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF};
        foreach (steps_words[i]) begin
            wait_for_all_roots();
            write_settings(steps_words[i], tol_words[i]);
            issue_value(32'h0001_0000, 0);
            issue_value(32'hFFFF_FFFF, 0);
        end
    endtask

    // random values in chunks, each chunk under fresh settings
    task automatic test_random_traffic(input int unsigned idle_pct, input int unsigned count);
        for (int unsigned n = 0; n < count; n++) begin
            if (n % 25 == 0)
                pick_random_settings();
            else if ($urandom_range(0, 99) < 3)
                wait_for_all_roots();
            issue_value(random_value(), idle_pct);
        end
    endtask

    // stimulus sequence
    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_register_extremes();
        test_random_traffic(14, 100);
        test_random_traffic(51, 100);
        test_random_traffic(0, 100);
        wait_for_all_roots();
        repeat (ITEM_CYCLES_MAX) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
